// ----- hw/rtl/mlfq_pkg.sv -----
// Shared constants, types and helpers for the multilevel feedback scheduler.
`default_nettype none

package mlfq_pkg;

  localparam int unsigned MaxTasks  = 64;
  localparam int unsigned NumLevels = 10;

  localparam int unsigned TaskIdxW = (MaxTasks > 1) ? $clog2(MaxTasks) : 1;
  localparam int unsigned LvlW     = (NumLevels > 1) ? $clog2(NumLevels) : 1;

  // Port field widths
  localparam int unsigned TaskW    = 6;
  localparam int unsigned LevelW   = 4;
  localparam int unsigned SliceW   = 8;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 8;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgSchedEnable = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgAdmitQueue  = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgAdmitLevel  = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgTimeSlice   = 2'd3;

  // Configuration reset values
  localparam logic              RstSchedEnable = 1'b1;
  localparam logic [LevelW-1:0] RstAdmitQueue  = 4'd0;
  localparam logic [LevelW-1:0] RstAdmitLevel  = 4'd1;
  localparam logic [SliceW-1:0] RstTimeSlice   = 8'd30;

  typedef logic [TaskIdxW-1:0] task_idx_t;
  typedef logic [LvlW-1:0]     lvl_t;

  // Update request for the queue descriptors
  typedef struct packed {
    logic      set_head;
    logic      set_tail;
    logic      set_ne;
    logic      clr_ne;
    lvl_t      q;
    task_idx_t head;
    task_idx_t tail;
  } qupd_t;

  // Saturate a level value to the last level
  function automatic lvl_t clamp_lvl(input logic [LevelW:0] v);
    lvl_t r;
    if (int'(v) >= int'(NumLevels)) begin
      r = lvl_t'(NumLevels - 1);
    end else begin
      r = lvl_t'(v);
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/mlfq_if.sv -----
// Valid/ready channel interfaces for scheduler items and results.
`default_nettype none

interface mlfq_in_if;
  import mlfq_pkg::*;
  logic             valid;
  logic             ready;
  logic             mode;
  logic [TaskW-1:0] task_id;
  modport source (output valid, mode, task_id, input ready);
  modport sink   (input valid, mode, task_id, output ready);
endinterface

interface mlfq_out_if;
  import mlfq_pkg::*;
  logic              valid;
  logic              ready;
  logic [TaskW-1:0]  next_task;
  logic [LevelW-1:0] next_level;
  logic [SliceW-1:0] slice;
  logic              switched;
  modport source (output valid, next_task, next_level, slice, switched, input ready);
  modport sink   (input valid, next_task, next_level, slice, switched, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/mlfq_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module mlfq_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 64
) (
  input  wire logic                                     clk_i,
  input  wire logic                                     we_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  wire logic [Width-1:0]                         wdata_i,
  input  wire logic                                     re_i,
  input  wire logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic      [Width-1:0]                         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// ----- hw/rtl/mlfq_queues.sv -----
// Per-level FIFO descriptors: head, tail, non-empty flags and lowest-level pick.
`default_nettype none

module mlfq_queues (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire mlfq_pkg::lvl_t                   sel_q_i,
  input  wire mlfq_pkg::qupd_t                  upd_i,
  output mlfq_pkg::task_idx_t                   head_o,
  output mlfq_pkg::task_idx_t                   tail_o,
  output logic [mlfq_pkg::NumLevels-1:0]        ne_o,
  output mlfq_pkg::lvl_t                        lowest_o
);
  import mlfq_pkg::*;

  task_idx_t            head_q [NumLevels];
  task_idx_t            tail_q [NumLevels];
  logic [NumLevels-1:0] ne_q;
  lvl_t                 lowest;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ne_q <= '0;
    end else begin
      if (upd_i.set_ne) begin
        ne_q[upd_i.q] <= 1'b1;
      end else if (upd_i.clr_ne) begin
        ne_q[upd_i.q] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (upd_i.set_head) begin
      head_q[upd_i.q] <= upd_i.head;
    end
    if (upd_i.set_tail) begin
      tail_q[upd_i.q] <= upd_i.tail;
    end
  end

  // Priority pick: lowest non-empty level wins
  always_comb begin
    lowest = '0;
    for (int i = NumLevels - 1; i >= 0; i--) begin
      if (ne_q[i]) begin
        lowest = lvl_t'(i);
      end
    end
  end

  assign head_o   = head_q[sel_q_i];
  assign tail_o   = tail_q[sel_q_i];
  assign ne_o     = ne_q;
  assign lowest_o = lowest;

endmodule

`default_nettype wire

// ----- hw/rtl/multilevel_feedback_scheduler.sv -----
// Multilevel feedback queue scheduler: level/link tables in RAM, FIFO descriptors in flops.
//
// Usage:
//   in_i  : one transaction per item. mode 0 is a scheduling tick, mode 1 admits
//           task_id into the configured entry queue at the configured level.
//   out_o : exactly one transaction per item: running task, its level, slice
//           reload and a switched flag (slice is zero unless switched).
//   cfg   : write-only port, cfg_we_i with cfg_idx_i/cfg_wdata_i; write only
//           while no item is in flight.
// Timing: an enabled tick reads the level at acceptance, then does demote/push, pop and
//   head advance, loading its result in the last; an admit does the admit write, then
//   a finishing step; a disabled tick only that step. Each step is one read-modify-write
//   pass through the level and link RAMs (one read and one write port each). One item
//   is in flight at a time; the next is accepted the cycle after the result loads.
// Reset: asynchronous, active low. Configuration returns to its defaults, all
//   queues are empty, task 0 runs and every task level reads as zero.
// Stall: a result waits in the output register; a new item can still be
//   accepted and worked on, and it holds in its last step until the output
//   register frees up.
`default_nettype none

module multilevel_feedback_scheduler (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  mlfq_in_if.sink                              in_i,
  mlfq_out_if.source                           out_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [mlfq_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  wire logic [mlfq_pkg::CfgDataW-1:0]   cfg_wdata_i
);
  import mlfq_pkg::*;

  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_TK_PUSH = 3'd1;
  localparam logic [2:0] S_TK_POP  = 3'd2;
  localparam logic [2:0] S_TK_HEAD = 3'd3;
  localparam logic [2:0] S_ADMIT   = 3'd4;
  localparam logic [2:0] S_LV_DONE = 3'd5;

  // Configuration
  logic              en_q;
  logic [LevelW-1:0] aq_q;
  logic [LevelW-1:0] al_q;
  logic [SliceW-1:0] slice_q;

  // Control
  logic [2:0]    state_q, state_d;
  task_idx_t     running_q, running_d;
  task_idx_t     id_q, id_d;
  lvl_t          popq_q, popq_d;
  logic          last_q, last_d;
  logic          sw_q, sw_d;
  logic          fwd_q, fwd_d;
  lvl_t          fwd_lvl_q, fwd_lvl_d;
  logic [MaxTasks-1:0] tl_vld_q;

  // Output register
  logic              out_vld_q, out_vld_d;
  logic [TaskW-1:0]  out_task_q, out_task_d;
  logic [LevelW-1:0] out_lvl_q, out_lvl_d;
  logic [SliceW-1:0] out_slice_q, out_slice_d;
  logic              out_sw_q, out_sw_d;

  // RAM ports
  logic      tl_we, tl_re;
  task_idx_t tl_waddr, tl_raddr;
  lvl_t      tl_wdata, tl_rdata;
  logic      lk_we, lk_re;
  task_idx_t lk_waddr, lk_raddr;
  task_idx_t lk_wdata, lk_rdata;

  // Queue descriptors
  lvl_t                 sel_q;
  qupd_t                qupd;
  task_idx_t            q_head, q_tail;
  logic [NumLevels-1:0] q_ne;
  lvl_t                 q_lowest;

  logic      in_acc, finish_ok, id_ok;
  lvl_t      old_lvl, new_lvl, adm_lvl, adm_q, res_lvl;
  task_idx_t push_id;
  logic      push_en;

  mlfq_ram #(.Width(LvlW), .Depth(MaxTasks)) u_level_ram (
    .clk_i   (clk_i),
    .we_i    (tl_we),
    .waddr_i (tl_waddr),
    .wdata_i (tl_wdata),
    .re_i    (tl_re),
    .raddr_i (tl_raddr),
    .rdata_o (tl_rdata)
  );

  mlfq_ram #(.Width(TaskIdxW), .Depth(MaxTasks)) u_link_ram (
    .clk_i   (clk_i),
    .we_i    (lk_we),
    .waddr_i (lk_waddr),
    .wdata_i (lk_wdata),
    .re_i    (lk_re),
    .raddr_i (lk_raddr),
    .rdata_o (lk_rdata)
  );

  mlfq_queues u_queues (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .sel_q_i  (sel_q),
    .upd_i    (qupd),
    .head_o   (q_head),
    .tail_o   (q_tail),
    .ne_o     (q_ne),
    .lowest_o (q_lowest)
  );

  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && (state_q == S_IDLE);
  assign finish_ok  = !out_vld_q || out_o.ready;
  assign id_ok      = (int'(in_i.task_id) < int'(MaxTasks));

  assign old_lvl = tl_vld_q[running_q] ? tl_rdata : '0;
  assign new_lvl = clamp_lvl((LevelW+1)'(old_lvl) + (LevelW+1)'(1));
  assign adm_lvl = clamp_lvl({1'b0, al_q});
  assign adm_q   = clamp_lvl({1'b0, aq_q});

  always_comb begin
    state_d    = state_q;
    running_d  = running_q;
    id_d       = id_q;
    popq_d     = popq_q;
    last_d     = last_q;
    sw_d       = sw_q;
    fwd_d      = fwd_q;
    fwd_lvl_d  = fwd_lvl_q;
    tl_we      = 1'b0;
    tl_waddr   = running_q;
    tl_wdata   = new_lvl;
    tl_re      = 1'b0;
    tl_raddr   = running_q;
    lk_re      = 1'b0;
    lk_raddr   = q_head;
    sel_q      = popq_q;
    push_en    = 1'b0;
    push_id    = running_q;
    qupd       = '0;
    res_lvl    = '0;
    out_vld_d  = out_vld_q && !out_o.ready;
    out_task_d = out_task_q;
    out_lvl_d  = out_lvl_q;
    out_slice_d = out_slice_q;
    out_sw_d   = out_sw_q;

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          tl_re = 1'b1;
          id_d  = task_idx_t'(in_i.task_id);
          fwd_d = 1'b0;
          sw_d  = !in_i.mode && en_q;
          if (in_i.mode) begin
            state_d = id_ok ? S_ADMIT : S_LV_DONE;
          end else begin
            state_d = en_q ? S_TK_PUSH : S_LV_DONE;
          end
        end
      end
      S_TK_PUSH: begin
        // demote the running task and append it to its new level
        tl_we    = 1'b1;
        tl_waddr = running_q;
        tl_wdata = new_lvl;
        sel_q    = new_lvl;
        push_en  = 1'b1;
        push_id  = running_q;
        state_d  = S_TK_POP;
      end
      S_TK_POP: begin
        sel_q     = q_lowest;
        popq_d    = q_lowest;
        running_d = q_head;
        last_d    = (q_head == q_tail);
        lk_re     = 1'b1;
        lk_raddr  = q_head;
        tl_re     = 1'b1;
        tl_raddr  = q_head;
        if (q_head == q_tail) begin
          qupd.clr_ne = 1'b1;
          qupd.q      = q_lowest;
        end
        state_d = S_TK_HEAD;
      end
      S_TK_HEAD: begin
        if (finish_ok) begin
          if (!last_q) begin
            qupd.set_head = 1'b1;
            qupd.q        = popq_q;
            qupd.head     = lk_rdata;
          end
          res_lvl = tl_vld_q[running_q] ? tl_rdata : '0;
          out_vld_d   = 1'b1;
          out_task_d  = TaskW'(running_q);
          out_lvl_d   = LevelW'(res_lvl);
          out_slice_d = sw_q ? slice_q : '0;
          out_sw_d    = sw_q;
          state_d     = S_IDLE;
        end
      end
      S_ADMIT: begin
        tl_we     = 1'b1;
        tl_waddr  = id_q;
        tl_wdata  = adm_lvl;
        sel_q     = adm_q;
        push_en   = 1'b1;
        push_id   = id_q;
        // level of the running task; forward when it is the one being written
        tl_re     = 1'b1;
        tl_raddr  = running_q;
        fwd_d     = (id_q == running_q);
        fwd_lvl_d = adm_lvl;
        state_d   = S_LV_DONE;
      end
      S_LV_DONE: begin
        if (finish_ok) begin
          res_lvl = fwd_q ? fwd_lvl_q : (tl_vld_q[running_q] ? tl_rdata : '0);
          out_vld_d   = 1'b1;
          out_task_d  = TaskW'(running_q);
          out_lvl_d   = LevelW'(res_lvl);
          out_slice_d = sw_q ? slice_q : '0;
          out_sw_d    = sw_q;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    // FIFO append at the selected level
    lk_we    = 1'b0;
    lk_waddr = q_tail;
    lk_wdata = push_id;
    if (push_en) begin
      qupd.q        = sel_q;
      qupd.set_tail = 1'b1;
      qupd.tail     = push_id;
      if (q_ne[sel_q]) begin
        lk_we = 1'b1;
      end else begin
        qupd.set_head = 1'b1;
        qupd.head     = push_id;
        qupd.set_ne   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      running_q <= '0;
      tl_vld_q  <= '0;
      out_vld_q <= 1'b0;
      en_q      <= RstSchedEnable;
      aq_q      <= RstAdmitQueue;
      al_q      <= RstAdmitLevel;
      slice_q   <= RstTimeSlice;
    end else begin
      state_q   <= state_d;
      running_q <= running_d;
      out_vld_q <= out_vld_d;
      if (tl_we) begin
        tl_vld_q[tl_waddr] <= 1'b1;
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgSchedEnable: en_q    <= cfg_wdata_i[0];
          CfgAdmitQueue:  aq_q    <= cfg_wdata_i[LevelW-1:0];
          CfgAdmitLevel:  al_q    <= cfg_wdata_i[LevelW-1:0];
          CfgTimeSlice:   slice_q <= cfg_wdata_i[SliceW-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    id_q        <= id_d;
    popq_q      <= popq_d;
    last_q      <= last_d;
    sw_q        <= sw_d;
    fwd_q       <= fwd_d;
    fwd_lvl_q   <= fwd_lvl_d;
    out_task_q  <= out_task_d;
    out_lvl_q   <= out_lvl_d;
    out_slice_q <= out_slice_d;
    out_sw_q    <= out_sw_d;
  end

  assign out_o.valid      = out_vld_q;
  assign out_o.next_task  = out_task_q;
  assign out_o.next_level = out_lvl_q;
  assign out_o.slice      = out_slice_q;
  assign out_o.switched   = out_sw_q;

  // The pop step always finds a queue: the demoted task was just pushed
  a_pop_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TK_POP) |-> (q_ne != '0))
    else $error("pop with all queues empty");

  // After the push step the target level holds at least the pushed task
  a_push_sets_ne: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_TK_PUSH) |=> q_ne[$past(sel_q)])
    else $error("pushed level not marked non-empty");

  // A non-switching result carries no slice reload
  a_slice_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_sw_q) |-> (out_slice_q == '0))
    else $error("slice reported without a switch");

  // Results are only loaded from a finishing step
  a_load_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_vld_q) |-> ($past(state_q) == S_TK_HEAD || $past(state_q) == S_LV_DONE))
    else $error("result loaded outside a finishing step");

endmodule

`default_nettype wire
